@@ hdl/lbp_pkg.sv @@
// Shared types and constants of the LSB-first bit packer.
// Used by lbp_in_stage, lbp_emitter and lsb_first_bit_packer; no dependencies.
package lbp_pkg;

    // Input field widths
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 63;
    localparam int LEN_W    = 6;

    // Output field widths
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 27;
    localparam int POS_W    = 32;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 96;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_PEEK   = 2'd1,
        OP_CLEAR  = 2'd2
    } lbp_opcode_t;

    typedef enum logic {
        KIND_WORD   = 1'b0,
        KIND_STATUS = 1'b1
    } lbp_kind_t;

    // One input word as it travels from the input register to the emitter
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
        logic [LEN_W-1:0]    width;
    } lbp_item_t;

endpackage

@@ hdl/lbp_in_stage.sv @@
// Input register of the bit packer: one-entry pipeline register on the slave side.
// Depends on lbp_pkg for the item struct.
module lbp_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lbp_pkg::lbp_item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lbp_pkg::lbp_item_t out_item
);
    import lbp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lbp_item_t item_reg;

    // Take a new word whenever the register is empty or drains this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

@@ hdl/lbp_emitter.sv @@
// Packing accumulator and result serializer of the bit packer.
// Holds the stream state and drives one result word per cycle while m_tready is high; depends on lbp_pkg.
module lbp_emitter #(
    parameter int WORD_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  lbp_pkg::lbp_item_t          in_item,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lbp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);
    import lbp_pkg::*;

    // Accumulator must hold a partial word plus the widest append
    localparam int ACC_W = WORD_BITS - 1 + VALUE_W;
    localparam int TOT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]   acc_reg,   acc_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [INDEX_W-1:0] count_reg, count_next;
    logic               busy_reg,  busy_next;
    logic               peek_reg,  peek_next;
    logic               err_reg,   err_next;

    logic               word_pending;
    logic               status_now;
    logic               load;
    logic [VALUE_W-1:0] value_mask;
    logic [VALUE_W-1:0] value_masked;
    logic [WORD_W-1:0]  word_field;
    logic [POS_W-1:0]   pos_field;
    lbp_kind_t          kind;

    // Full words go out first, then a peeked partial word, then the status word
    assign word_pending = total_reg >= TOT_W'(WORD_BITS);
    assign status_now   = !word_pending && !peek_reg;
    assign in_ready     = !busy_reg || (m_tready && status_now);
    assign load         = in_valid && in_ready;

    // Keep only the low width bits of the appended value
    assign value_mask   = ~({VALUE_W{1'b1}} << in_item.width);
    assign value_masked = in_item.value & value_mask;

    // Result fields
    assign kind       = status_now ? KIND_STATUS : KIND_WORD;
    assign word_field = status_now ? '0 : WORD_W'(acc_reg[WORD_BITS-1:0]);
    assign pos_field  = status_now
                        ? (POS_W'(count_reg) * POS_W'(WORD_BITS) + POS_W'(total_reg))
                        : '0;

    assign m_tvalid = busy_reg;
    assign m_tuser  = kind;
    assign m_tlast  = status_now;
    assign m_tdata  = {3'b000,
                       status_now && err_reg,
                       pos_field,
                       !word_pending && peek_reg,
                       count_reg,
                       word_field};

    // Advance the serializer and load the next item
    always_comb begin
        acc_next   = acc_reg;
        total_next = total_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        peek_next  = peek_reg;
        err_next   = err_reg;

        if (busy_reg && m_tready) begin
            if (word_pending) begin
                acc_next   = acc_reg >> WORD_BITS;
                total_next = total_reg - TOT_W'(WORD_BITS);
                count_next = count_reg + INDEX_W'(1);
            end else if (peek_reg) begin
                peek_next = 1'b0;
            end else begin
                busy_next = 1'b0;
            end
        end

        if (load) begin
            busy_next = 1'b1;
            err_next  = 1'b0;
            peek_next = 1'b0;
            case (in_item.opcode)
                OP_APPEND: begin
                    if (in_item.width == '0) begin
                        err_next = 1'b1;
                    end else begin
                        acc_next   = acc_reg | (ACC_W'(value_masked) << total_reg);
                        total_next = total_reg + TOT_W'(in_item.width);
                    end
                end
                OP_PEEK: begin
                    peek_next = total_reg != '0;
                end
                OP_CLEAR: begin
                    acc_next   = '0;
                    total_next = '0;
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            total_reg <= '0;
            count_reg <= '0;
            busy_reg  <= 1'b0;
            peek_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            acc_reg   <= acc_next;
            total_reg <= total_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            peek_reg  <= peek_next;
            err_reg   <= err_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Between items the accumulator holds less than one word
    a_idle_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> total_reg < TOT_W'(WORD_BITS))
        else $error("idle with a complete word left in the accumulator");

    // A peek is pending only for a nonempty partial word
    a_peek_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        peek_reg |-> (total_reg != '0) && (total_reg < TOT_W'(WORD_BITS)) && busy_reg)
        else $error("peek pending without a partial word");

    // Each full word taken advances the word count by one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && m_tready && word_pending) |=>
            count_reg == $past(count_reg) + INDEX_W'(1))
        else $error("word count did not advance after a full word");

    // A new item is loaded only when the status word leaves or the unit is idle
    a_load_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !(m_tready && status_now)) |-> !in_ready)
        else $error("item loaded while results still pending");
`endif

endmodule

@@ hdl/lsb_first_bit_packer.sv @@
// Top level of the LSB-first bit packer: input register feeding the emitter.
// Depends on lbp_pkg, lbp_in_stage and lbp_emitter.
//
// Usage:
//   Slave channel s_*: one word per command. s_tuser carries the opcode
//   (append, peek, clear); s_tdata carries the value and the bit count.
//   Master channel m_*: result words. Each append gives one word for every
//   WORD_BITS-bit word it completes, a peek gives the zero-padded partial word
//   if any bits are pending, and every command ends with one status word
//   (m_tuser high, m_tlast high) holding the word count and bit position.
//   The first result word is presented once the command has passed the input
//   register and been loaded into the emitter's registers.
//   Throughput: one result word per cycle while m_tready is high, limited
//   by the single result channel of the emitter; a command gives up to 3
//   results at WORD_BITS = 32. The next command is loaded in the cycle
//   its predecessor's status word is taken, so commands follow back to back.
//   Reset clears the stream: no partial bits, word count zero, no results.
//   When the receiver holds m_tready low the current result holds steady and
//   the input register fills, then s_tready drops.
module lsb_first_bit_packer #(
    parameter int WORD_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, low bit up: value[62:0], width[68:63], zero pad[71:69]
    input  logic [lbp_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: opcode[1:0]
    input  logic [lbp_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, low bit up: word[31:0], word_index[58:32], is_partial[59],
    // bit_position[91:60], error[92], zero pad[95:93]
    output logic [lbp_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: kind (0 word, 1 status)
    output logic                           m_tuser,
    // m_tlast: last result of a command
    output logic                           m_tlast
);
    import lbp_pkg::*;

    lbp_item_t s_item;
    lbp_item_t q_item;
    logic      q_valid;
    logic      q_ready;

    assign s_item.opcode = s_tuser;
    assign s_item.value  = s_tdata[VALUE_W-1:0];
    assign s_item.width  = s_tdata[VALUE_W+LEN_W-1:VALUE_W];

    lbp_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    lbp_emitter #(
        .WORD_BITS (WORD_BITS)
    ) u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ test/lsb_first_bit_packer_tb.sv @@
// Self-checking testbench for lsb_first_bit_packer: random and directed commands
// on the s_ stream, with results predicted and checked word by word on the m_ stream.
// Depends on lbp_pkg and the lsb_first_bit_packer RTL only.
module lsb_first_bit_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbp_pkg::*;

    // Opcode that the block ignores apart from its status word
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_CMDS = 308;
    // No idling once fewer commands than this are left to send
    localparam int QUIET_TAIL  = 40;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                sync;   // wait until every result is back first
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
        logic [LEN_W-1:0]    width;
    } packer_cmd_t;

    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] word_index;
        logic               is_partial;
        logic [POS_W-1:0]   bit_position;
        logic               error;
        logic               last;
    } packer_result_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OPCODE_W-1:0]  s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Predicted packer state
    logic [WORD_W-1:0]  pend_word;
    logic [4:0]         pend_bits;
    logic [INDEX_W-1:0] words_done;

    packer_cmd_t    cmd_queue[$];
    packer_result_t predicted_words[$];
    packer_cmd_t    cur_cmd;
    int             accepted_cnt = 0;
    int             total_cmds   = 0;
    int             mismatch_cnt = 0;
    int             tx_gap       = 0;
    int             rx_gap       = 0;
    logic           rx_hold      = 1'b0;

    lsb_first_bit_packer #(.WORD_BITS(32)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Work out the words one command produces and advance the packer state
    function automatic void pack_bits(packer_cmd_t c);
        logic [127:0]       acc;
        logic [VALUE_W-1:0] bits;
        int                 total;
        logic               err;
        packer_result_t     r;
        err = 1'b0;
        case (c.opcode)
            OP_APPEND: begin
                if (c.width == 0) begin
                    err = 1'b1;
                end else begin
                    bits  = c.value & ((63'd1 << c.width) - 63'd1);
                    acc   = {96'd0, pend_word} | ({65'd0, bits} << pend_bits);
                    total = pend_bits + c.width;
                    while (total >= WORD_W) begin
                        r = '0;
                        r.kind       = KIND_WORD;
                        r.word       = acc[WORD_W-1:0];
                        r.word_index = words_done;
                        predicted_words.push_back(r);
                        words_done++;
                        acc   = acc >> WORD_W;
                        total -= WORD_W;
                    end
                    pend_word = acc[WORD_W-1:0];
                    pend_bits = total[4:0];
                end
            end
            OP_PEEK: begin
                if (pend_bits != 0) begin
                    r = '0;
                    r.kind       = KIND_WORD;
                    r.word       = pend_word;
                    r.word_index = words_done;
                    r.is_partial = 1'b1;
                    predicted_words.push_back(r);
                end
            end
            OP_CLEAR: begin
                pend_word  = '0;
                pend_bits  = '0;
                words_done = '0;
            end
            default: ;
        endcase
        // Status closes every command; position is words*32 + offset
        r = '0;
        r.kind         = KIND_STATUS;
        r.word_index   = words_done;
        r.bit_position = {words_done, pend_bits};
        r.error        = err;
        r.last         = 1'b1;
        predicted_words.push_back(r);
    endfunction

    function automatic void report_mismatch(string what, packer_result_t exp_r,
                                            packer_result_t got_r);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, what);
            $display("  exp: kind=%0d word=%h idx=%0d part=%0d pos=%0d err=%0d last=%0d",
                     exp_r.kind, exp_r.word, exp_r.word_index, exp_r.is_partial,
                     exp_r.bit_position, exp_r.error, exp_r.last);
            $display("  got: kind=%0d word=%h idx=%0d part=%0d pos=%0d err=%0d last=%0d",
                     got_r.kind, got_r.word, got_r.word_index, got_r.is_partial,
                     got_r.bit_position, got_r.error, got_r.last);
        end
    endfunction

    task automatic add_cmd(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value,
                           logic [LEN_W-1:0] width, logic sync);
        packer_cmd_t c;
        c.sync   = sync;
        c.opcode = op;
        c.value  = value;
        c.width  = width;
        cmd_queue.push_back(c);
        total_cmds++;
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2:       return 63'(1) << $urandom_range(0, 62);
            default: return VALUE_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] rand_width();
        case ($urandom_range(0, 9))
            0, 1:    return LEN_W'($urandom_range(1, 8));
            2:       return LEN_W'(32);
            3, 4:    return LEN_W'($urandom_range(56, 63));
            default: return LEN_W'($urandom_range(1, 63));
        endcase
    endfunction

    // Sender: present queued commands, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pack_bits(cur_cmd);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_queue.size() != 0 &&
                             !(cmd_queue[0].sync && predicted_words.size() != 0)) begin
                    cur_cmd = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, cur_cmd.width, cur_cmd.value};
                    s_tuser  <= cur_cmd.opcode;
                    if (cmd_queue.size() >= QUIET_TAIL && $urandom_range(0, 5) == 0)
                        tx_gap = $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each taken word against the oldest prediction, stall at random
    always @(posedge aclk) begin
        packer_result_t got_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_r.kind         = m_tuser;
                got_r.word         = m_tdata[31:0];
                got_r.word_index   = m_tdata[58:32];
                got_r.is_partial   = m_tdata[59];
                got_r.bit_position = m_tdata[91:60];
                got_r.error        = m_tdata[92];
                got_r.last         = m_tlast;
                if (predicted_words.size() == 0)
                    report_mismatch("result word with nothing expected", '0, got_r);
                else if (got_r !== predicted_words[0])
                    report_mismatch("result word mismatch", predicted_words.pop_front(),
                                    got_r);
                else
                    void'(predicted_words.pop_front());
            end
            if (rx_gap != 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else if (rx_hold) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (cmd_queue.size() >= QUIET_TAIL && $urandom_range(0, 4) == 0)
                    rx_gap = $urandom_range(1, 5);
            end
        end
    end

    // Long receiver stall while the sender keeps offering, so the input backs up
    initial begin
        do @(negedge aclk); while (accepted_cnt < 60);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Reset, stimulus and end of run
    initial begin
        int sel;
        int drain;
        pend_word  = '0;
        pend_bits  = '0;
        words_done = '0;

        // Directed: empty peek, zero width, word crossings, masking, unused opcode
        add_cmd(OP_CLEAR,  rand_value(), rand_width(), 1'b0);
        add_cmd(OP_PEEK,   rand_value(), rand_width(), 1'b0);
        add_cmd(OP_APPEND, rand_value(), 6'd0,         1'b0);
        add_cmd(OP_APPEND, 63'd1,        6'd1,         1'b0);
        add_cmd(OP_PEEK,   '0,           '0,           1'b0);
        add_cmd(OP_APPEND, '1,           6'd63,        1'b0);
        add_cmd(OP_PEEK,   '1,           '1,           1'b0);
        add_cmd(OP_APPEND, 63'h7fff_ffff, 6'd31,       1'b0);
        add_cmd(OP_APPEND, rand_value(), 6'd63,        1'b0);
        add_cmd(OP_APPEND, '1,           6'd4,         1'b0);
        add_cmd(OP_UNUSED, rand_value(), rand_width(), 1'b0);
        add_cmd(OP_APPEND, '1,           6'd0,         1'b0);
        add_cmd(OP_APPEND, 63'h1234_5678_9abc_def0, 6'd32, 1'b0);
        add_cmd(OP_APPEND, '0,           6'd63,        1'b0);
        add_cmd(OP_APPEND, 63'h5555_5555_5555_5555, 6'd63, 1'b0);
        add_cmd(OP_PEEK,   '0,           '0,           1'b0);
        add_cmd(OP_CLEAR,  '1,           '1,           1'b0);
        add_cmd(OP_APPEND, 63'h0000_0000_dead_beef, 6'd32, 1'b0);
        add_cmd(OP_APPEND, '0,           6'd1,         1'b0);
        add_cmd(OP_PEEK,   '0,           '0,           1'b0);
        add_cmd(OP_UNUSED, '0,           6'd0,         1'b0);
        add_cmd(OP_CLEAR,  '0,           '0,           1'b0);

        // Random: mostly appends, with peeks, clears and rejects mixed in
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 72)
                add_cmd(OP_APPEND, rand_value(), rand_width(), i == 0 || i == 150);
            else if (sel < 84)
                add_cmd(OP_PEEK, rand_value(), rand_width(), 1'b0);
            else if (sel < 89)
                add_cmd(OP_CLEAR, rand_value(), rand_width(), 1'b0);
            else if (sel < 95)
                add_cmd(OP_APPEND, rand_value(), 6'd0, 1'b0);
            else
                add_cmd(OP_UNUSED, rand_value(), LEN_W'($urandom), 1'b0);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for all commands, then for the last results to drain
        do @(negedge aclk); while (accepted_cnt < total_cmds);
        drain = 0;
        while (predicted_words.size() != 0 && drain < 2000) begin
            @(negedge aclk);
            drain++;
        end
        while (predicted_words.size() != 0)
            report_mismatch("expected result word never came", predicted_words.pop_front(),
                            '0);
        repeat (20) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
